### rtl/lz78e_pkg.sv
// Shared constants and types for the LZ78 byte encoder.
// Used by every module of the block; no dependencies.
package lz78e_pkg;

  localparam int DICT_DEPTH    = 4096;  // default dictionary entries
  localparam int MAX_CODE_BITS = 12;    // ceiling applied to max_bits

  localparam int BYTE_W   = 8;
  localparam int PCODE_W  = 12;  // prefix_code port
  localparam int CWIDTH_W = 4;   // code_width port and max_bits register

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MAX_BITS = 1'b0;  // word index of max_bits
  localparam logic [CWIDTH_W-1:0] MAX_BITS_RESET = 4'd12;

  // Memory commands from the controller to the dictionary
  typedef struct packed {
    logic head_rd;  // read child-list head of a code
    logic node_rd;  // read a node (prefix, byte, sibling)
    logic ins_wr;   // insert: write new node and relink parent head
  } dict_ctl_t;

endpackage

### rtl/lz78_byte_encoder_top.sv
// LZ78 byte encoder, top level: APB registers, match controller and dictionary.
// Depends on lz78e_pkg, lz78e_cfg_regs, lz78e_ctrl and lz78e_dict_mem.
//
// Usage:
//   Input channel (in_valid / in_stall): one byte per item, is_last marks the
//   final byte of a stream. Output channel (out_valid / out_stall): one token
//   (prefix_code, code_width, symbol, end_of_stream) per miss or final byte;
//   a byte that extends the current match gives no token.
//   max_bits is written over APB at address 0 while the block is idle.
// Sequence:
//   One item at a time: in_stall stays high until the current byte is done.
//   A final byte goes straight to the emit state. Other bytes first read the
//   head of the current code's child list, then walk its dictionary nodes
//   (one node-memory read per cycle, at most 256 nodes); a match extends the
//   code and ends there, a miss goes on to the emit state. The emit state
//   loads the token into the output register once that register is free.
// Reset: after rst the head memory is swept to zero, one entry per cycle, and
//   in_stall stays high until all DICT_DEPTH entries are swept; APB writes still work.
// Stall: a token waits in the output register while out_stall is high; the
//   next byte is still taken and held until the register frees up.
module lz78_byte_encoder_top #(
  parameter int DICT_DEPTH = lz78e_pkg::DICT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lz78e_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lz78e_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lz78e_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lz78e_pkg::BYTE_W-1:0]        data_byte,
  input  logic                                is_last,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lz78e_pkg::PCODE_W-1:0]       prefix_code,
  output logic [lz78e_pkg::CWIDTH_W-1:0]      code_width,
  output logic [lz78e_pkg::BYTE_W-1:0]        symbol,
  output logic                                end_of_stream
);

  localparam int CW = $clog2(DICT_DEPTH);

  logic [lz78e_pkg::CWIDTH_W-1:0] max_bits;
  logic                           clear_busy;
  lz78e_pkg::dict_ctl_t           ctl;
  logic [CW-1:0]                  head_addr;
  logic [CW-1:0]                  node_addr;
  logic [CW-1:0]                  ins_code;
  logic [CW-1:0]                  ins_prefix;
  logic [lz78e_pkg::BYTE_W-1:0]   ins_byte;
  logic [CW-1:0]                  ins_sibling;
  logic [CW-1:0]                  head_rdata;
  logic [CW-1:0]                  node_prefix;
  logic [lz78e_pkg::BYTE_W-1:0]   node_byte;
  logic [CW-1:0]                  node_sibling;

  lz78e_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_bits (max_bits)
  );

  lz78e_ctrl #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .max_bits      (max_bits),
    .clear_busy    (clear_busy),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .prefix_code   (prefix_code),
    .code_width    (code_width),
    .symbol        (symbol),
    .end_of_stream (end_of_stream),
    .ctl           (ctl),
    .head_addr     (head_addr),
    .node_addr     (node_addr),
    .ins_code      (ins_code),
    .ins_prefix    (ins_prefix),
    .ins_byte      (ins_byte),
    .ins_sibling   (ins_sibling),
    .head_rdata    (head_rdata),
    .node_prefix   (node_prefix),
    .node_byte     (node_byte),
    .node_sibling  (node_sibling)
  );

  lz78e_dict_mem #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_dict (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .head_addr    (head_addr),
    .node_addr    (node_addr),
    .ins_code     (ins_code),
    .ins_prefix   (ins_prefix),
    .ins_byte     (ins_byte),
    .ins_sibling  (ins_sibling),
    .head_rdata   (head_rdata),
    .node_prefix  (node_prefix),
    .node_byte    (node_byte),
    .node_sibling (node_sibling),
    .clear_busy   (clear_busy)
  );

endmodule

### rtl/lz78e_cfg_regs.sv
// APB register file for the LZ78 byte encoder: holds max_bits.
// Depends on lz78e_pkg.
module lz78e_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lz78e_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lz78e_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lz78e_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready,
  output logic [lz78e_pkg::CWIDTH_W-1:0]        max_bits
);

  logic reg_sel;
  logic wr_en;

  // byte offset bits are ignored, the word index selects the register
  assign reg_sel = (paddr[lz78e_pkg::APB_ADDR_W-1] == lz78e_pkg::REG_MAX_BITS);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bits <= lz78e_pkg::MAX_BITS_RESET;
    end else if (wr_en) begin
      max_bits <= pwdata[lz78e_pkg::CWIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = lz78e_pkg::APB_DATA_W'(max_bits);
    end
  end

endmodule

### rtl/lz78e_dict_mem.sv
// Dictionary storage: head memory (first child per code) and node memory
// (prefix, byte, next sibling per code). Head memory is swept to zero after reset.
// Depends on lz78e_pkg.
module lz78e_dict_mem #(
  parameter int DICT_DEPTH = lz78e_pkg::DICT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lz78e_pkg::dict_ctl_t           ctl,
  input  logic [$clog2(DICT_DEPTH)-1:0]  head_addr,
  input  logic [$clog2(DICT_DEPTH)-1:0]  node_addr,
  input  logic [$clog2(DICT_DEPTH)-1:0]  ins_code,
  input  logic [$clog2(DICT_DEPTH)-1:0]  ins_prefix,
  input  logic [lz78e_pkg::BYTE_W-1:0]   ins_byte,
  input  logic [$clog2(DICT_DEPTH)-1:0]  ins_sibling,
  output logic [$clog2(DICT_DEPTH)-1:0]  head_rdata,
  output logic [$clog2(DICT_DEPTH)-1:0]  node_prefix,
  output logic [lz78e_pkg::BYTE_W-1:0]   node_byte,
  output logic [$clog2(DICT_DEPTH)-1:0]  node_sibling,
  output logic                           clear_busy
);

  localparam int CW = $clog2(DICT_DEPTH);
  localparam int NW = 2 * CW + lz78e_pkg::BYTE_W;
  localparam logic [CW-1:0] LAST_ADDR = CW'(DICT_DEPTH - 1);

  logic [CW-1:0] head_mem [DICT_DEPTH];
  logic [NW-1:0] node_mem [DICT_DEPTH];

  logic [CW-1:0] sweep_addr;
  logic          hw_en;
  logic [CW-1:0] hw_addr;
  logic [CW-1:0] hw_data;
  logic [NW-1:0] node_q;

  // sweep owns the head write port until it finishes
  always_comb begin
    hw_en   = clear_busy || ctl.ins_wr;
    hw_addr = clear_busy ? sweep_addr : ins_prefix;
    hw_data = clear_busy ? '0 : ins_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      sweep_addr <= '0;
    end else if (clear_busy) begin
      sweep_addr <= sweep_addr + CW'(1);
      if (sweep_addr == LAST_ADDR) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      head_mem[hw_addr] <= hw_data;
    end
    if (ctl.head_rd) begin
      head_rdata <= head_mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_wr) begin
      node_mem[ins_code] <= {ins_prefix, ins_byte, ins_sibling};
    end
    if (ctl.node_rd) begin
      node_q <= node_mem[node_addr];
    end
  end

  assign node_prefix  = node_q[NW-1 -: CW];
  assign node_byte    = node_q[CW +: lz78e_pkg::BYTE_W];
  assign node_sibling = node_q[CW-1:0];

endmodule

### rtl/lz78e_ctrl.sv
// Match controller: walks the child list of the current match code, emits
// tokens into the output register and issues dictionary inserts.
// Depends on lz78e_pkg; drives lz78e_dict_mem.
module lz78e_ctrl #(
  parameter int DICT_DEPTH = lz78e_pkg::DICT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lz78e_pkg::CWIDTH_W-1:0]  max_bits,
  input  logic                            clear_busy,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lz78e_pkg::BYTE_W-1:0]    data_byte,
  input  logic                            is_last,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lz78e_pkg::PCODE_W-1:0]   prefix_code,
  output logic [lz78e_pkg::CWIDTH_W-1:0]  code_width,
  output logic [lz78e_pkg::BYTE_W-1:0]    symbol,
  output logic                            end_of_stream,
  // dictionary
  output lz78e_pkg::dict_ctl_t            ctl,
  output logic [$clog2(DICT_DEPTH)-1:0]   head_addr,
  output logic [$clog2(DICT_DEPTH)-1:0]   node_addr,
  output logic [$clog2(DICT_DEPTH)-1:0]   ins_code,
  output logic [$clog2(DICT_DEPTH)-1:0]   ins_prefix,
  output logic [lz78e_pkg::BYTE_W-1:0]    ins_byte,
  output logic [$clog2(DICT_DEPTH)-1:0]   ins_sibling,
  input  logic [$clog2(DICT_DEPTH)-1:0]   head_rdata,
  input  logic [$clog2(DICT_DEPTH)-1:0]   node_prefix,
  input  logic [lz78e_pkg::BYTE_W-1:0]    node_byte,
  input  logic [$clog2(DICT_DEPTH)-1:0]   node_sibling
);

  localparam int CW  = $clog2(DICT_DEPTH);
  localparam int BLW = $clog2(CW + 1);
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(DICT_DEPTH);
  localparam logic [4:0]  MAXB    = 5'(lz78e_pkg::MAX_CODE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_NODE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                       state, state_next;
  logic [CW-1:0]                    match, match_next;
  logic [CW-1:0]                    next_code, next_code_next;
  logic [lz78e_pkg::BYTE_W-1:0]     byte_q, byte_q_next;
  logic                             last_q, last_q_next;
  logic [CW-1:0]                    cur_code, cur_code_next;
  logic                             first, first_next;
  logic [CW-1:0]                    head_val, head_val_next;
  logic                             head_ok, head_ok_next;

  logic                             out_valid_next;
  logic [lz78e_pkg::PCODE_W-1:0]    prefix_code_next;
  logic [lz78e_pkg::CWIDTH_W-1:0]   code_width_next;
  logic [lz78e_pkg::BYTE_W-1:0]     symbol_next;
  logic                             end_of_stream_next;

  logic                             in_take;
  logic [CW:0]                      nc1;
  logic [4:0]                       lim_bits;
  logic                             over_limit;

  function automatic logic [BLW-1:0] bit_len(input logic [CW-1:0] v);
    logic [BLW-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) n = BLW'(i + 1);
    end
    return n;
  endfunction

  assign in_stall = (state != ST_IDLE) || clear_busy;
  assign in_take  = in_valid && !in_stall;

  // code count limit: 2^min(max_bits, MAX_CODE_BITS), capped at the depth
  always_comb begin
    nc1        = (CW + 1)'(next_code) + (CW + 1)'(1);
    lim_bits   = ({1'b0, max_bits} > MAXB) ? MAXB : {1'b0, max_bits};
    over_limit = ((nc1 >> lim_bits) != '0) || (nc1 >= DEPTH_C);
  end

  assign head_addr   = match;
  assign ins_code    = nc1[CW-1:0];
  assign ins_prefix  = match;
  assign ins_byte    = byte_q;
  assign ins_sibling = head_ok ? head_val : '0;

  always_comb begin
    state_next         = state;
    match_next         = match;
    next_code_next     = next_code;
    byte_q_next        = byte_q;
    last_q_next        = last_q;
    cur_code_next      = cur_code;
    first_next         = first;
    head_val_next      = head_val;
    head_ok_next       = head_ok;
    out_valid_next     = out_valid && out_stall;
    prefix_code_next   = prefix_code;
    code_width_next    = code_width;
    symbol_next        = symbol;
    end_of_stream_next = end_of_stream;
    ctl                = '0;
    node_addr          = head_rdata;

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          byte_q_next = data_byte;
          last_q_next = is_last;
          if (is_last) begin
            state_next = ST_EMIT;
          end else begin
            ctl.head_rd = 1'b1;
            state_next  = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        head_val_next = head_rdata;
        // a head from an earlier dictionary generation points out of range
        // or at a node whose prefix differs; checked here and in ST_NODE
        if (head_rdata != '0 && head_rdata <= next_code) begin
          ctl.node_rd   = 1'b1;
          node_addr     = head_rdata;
          cur_code_next = head_rdata;
          first_next    = 1'b1;
          state_next    = ST_NODE;
        end else begin
          head_ok_next = 1'b0;
          state_next   = ST_EMIT;
        end
      end
      ST_NODE: begin
        if (first && node_prefix != match) begin
          head_ok_next = 1'b0;
          state_next   = ST_EMIT;
        end else begin
          if (first) head_ok_next = 1'b1;
          if (node_byte == byte_q) begin
            match_next = cur_code;
            state_next = ST_IDLE;
          end else if (node_sibling != '0) begin
            ctl.node_rd   = 1'b1;
            node_addr     = node_sibling;
            cur_code_next = node_sibling;
            first_next    = 1'b0;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next     = 1'b1;
          prefix_code_next   = lz78e_pkg::PCODE_W'(match);
          code_width_next    = lz78e_pkg::CWIDTH_W'(bit_len(next_code));
          symbol_next        = byte_q;
          end_of_stream_next = last_q;
          match_next         = '0;
          state_next         = ST_IDLE;
          if (last_q) begin
            next_code_next = '0;
          end else begin
            ctl.ins_wr     = (nc1 < DEPTH_C);
            next_code_next = over_limit ? '0 : nc1[CW-1:0];
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      match     <= '0;
      next_code <= '0;
      head_ok   <= 1'b0;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      match     <= match_next;
      next_code <= next_code_next;
      head_ok   <= head_ok_next;
      first     <= first_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_q        <= byte_q_next;
    last_q        <= last_q_next;
    cur_code      <= cur_code_next;
    head_val      <= head_val_next;
    prefix_code   <= prefix_code_next;
    code_width    <= code_width_next;
    symbol        <= symbol_next;
    end_of_stream <= end_of_stream_next;
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != ST_IDLE)
    else $error("item accepted while previous one still in progress");

  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_NODE |-> (cur_code != '0 && cur_code <= next_code))
    else $error("walking a node outside the live code range");

  a_insert_code: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_wr |=> (next_code == '0 || next_code == $past(ins_code)))
    else $error("next_code does not follow the inserted code");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_valid && out_stall) |=> state == ST_EMIT)
    else $error("token dropped while output register was full");
`endif

endmodule
